// ===== rtl/core/smtl_pkg.sv =====
// Shared types, codes and helpers for the stepper move-to-limit controller.
package smtl_pkg;

    localparam int PERIOD_W = 16;
    localparam int CFG_AW   = 5;
    localparam int CFG_DW   = 32;

    typedef logic [PERIOD_W-1:0] t_period;

    localparam t_period PERIOD_MAX = {PERIOD_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        POS_OPEN    = 2'd0,
        POS_CLOSE   = 2'd1,
        POS_BETWEEN = 2'd2
    } t_pos;

    typedef enum logic [2:0] {
        REG_TIMEOUT   = 3'd0,
        REG_RAMP_INT  = 3'd1,
        REG_START_PER = 3'd2,
        REG_END_PER   = 3'd3,
        REG_RAMP_INC  = 3'd4,
        REG_TICKS_MS  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [7:0]  ramp_interval_ms;
        logic [15:0] start_period;
        logic [15:0] end_period;
        logic [7:0]  ramp_increment;
        logic [15:0] ticks_per_ms;
    } t_cfg;

    typedef struct packed {
        logic       step_level;
        logic       direction;
        logic       driver_enable;
        logic       busy_res;
        logic       done_res;
        logic       done_code;
        logic [1:0] position;
    } t_result;

    localparam logic [15:0] RST_TIMEOUT   = 16'd2000;
    localparam logic [7:0]  RST_RAMP_INT  = 8'd30;
    localparam logic [15:0] RST_START_PER = 16'd500;
    localparam logic [15:0] RST_END_PER   = 16'd700;
    localparam logic [7:0]  RST_RAMP_INC  = 8'd5;
    localparam logic [15:0] RST_TICKS_MS  = 16'd1000;

    // Clamp a 16-bit register value into the period width.
    function automatic t_period sat_start(input logic [15:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'(PERIOD_MAX)) begin
            return PERIOD_MAX;
        end
        return w[PERIOD_W-1:0];
    endfunction

endpackage

// ===== rtl/core/stepper_move_to_limit_top.sv =====
// Top level of the stepper move-to-limit controller with step-period ramp.
// Each input transaction (tick, open or close request, plus both limit switch
// levels) yields exactly one result transaction. The move state registers are
// updated in a single pass of compare and increment logic when a transaction is
// accepted, and the result is captured in an output register, so a new
// transaction is accepted every cycle as long as that register is empty or being
// drained. o_out_valid rises in the cycle after acceptance.
// Configuration goes through the APB port at byte address 4*index and should be
// written only while no move is in progress and no result is pending.
module stepper_move_to_limit_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [smtl_pkg::CFG_AW-1:0] paddr,
    input  logic [smtl_pkg::CFG_DW-1:0] pwdata,
    output logic [smtl_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_cmd,
    input  logic                        i_open_limit,
    input  logic                        i_close_limit,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_step_level,
    output logic                        o_direction,
    output logic                        o_driver_enable,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic                        o_done_code,
    output logic [1:0]                  o_position
);
    import smtl_pkg::*;

    t_cfg    w_cfg;
    t_result w_res;
    t_result r_res;
    logic    r_out_valid;
    logic    w_fire;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_fire     = i_in_valid && !o_in_stall;

    smtl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    smtl_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_cmd         (i_cmd),
        .i_open_limit  (i_open_limit),
        .i_close_limit (i_close_limit),
        .i_cfg         (w_cfg),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= i_in_valid;
        end
    end

    // payload holds while the result transaction is stalled
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_step_level    = r_res.step_level;
    assign o_direction     = r_res.direction;
    assign o_driver_enable = r_res.driver_enable;
    assign o_busy_res      = r_res.busy_res;
    assign o_done_res      = r_res.done_res;
    assign o_done_code     = r_res.done_code;
    assign o_position      = r_res.position;

endmodule

// ===== rtl/core/smtl_regs.sv =====
// APB configuration register file for the stepper move-to-limit controller.
module smtl_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [smtl_pkg::CFG_AW-1:0] paddr,
    input  logic [smtl_pkg::CFG_DW-1:0] pwdata,
    output logic [smtl_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    output smtl_pkg::t_cfg              o_cfg
);
    import smtl_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms       <= RST_TIMEOUT;
            r_cfg.ramp_interval_ms <= RST_RAMP_INT;
            r_cfg.start_period     <= RST_START_PER;
            r_cfg.end_period       <= RST_END_PER;
            r_cfg.ramp_increment   <= RST_RAMP_INC;
            r_cfg.ticks_per_ms     <= RST_TICKS_MS;
        end else if (w_wr) begin
            case (w_idx)
                REG_TIMEOUT:   r_cfg.timeout_ms       <= pwdata[15:0];
                REG_RAMP_INT:  r_cfg.ramp_interval_ms <= pwdata[7:0];
                REG_START_PER: r_cfg.start_period     <= pwdata[15:0];
                REG_END_PER:   r_cfg.end_period       <= pwdata[15:0];
                REG_RAMP_INC:  r_cfg.ramp_increment   <= pwdata[7:0];
                REG_TICKS_MS:  r_cfg.ticks_per_ms     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TIMEOUT:   prdata = 32'(r_cfg.timeout_ms);
            REG_RAMP_INT:  prdata = 32'(r_cfg.ramp_interval_ms);
            REG_START_PER: prdata = 32'(r_cfg.start_period);
            REG_END_PER:   prdata = 32'(r_cfg.end_period);
            REG_RAMP_INC:  prdata = 32'(r_cfg.ramp_increment);
            REG_TICKS_MS:  prdata = 32'(r_cfg.ticks_per_ms);
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/smtl_core.sv =====
// Move state and single-pass next-state logic for one transaction.
module smtl_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [1:0]        i_cmd,
    input  logic              i_open_limit,
    input  logic              i_close_limit,
    input  smtl_pkg::t_cfg    i_cfg,
    output smtl_pkg::t_result o_res
);
    import smtl_pkg::*;

    logic        r_moving, n_moving;
    logic        r_dir, n_dir;
    logic        r_step, n_step;
    logic        r_ramping, n_ramping;
    t_period     r_period, n_period;
    t_period     r_period_count, n_period_count;
    logic [15:0] r_tick_count, n_tick_count;
    logic [15:0] r_elapsed, n_elapsed;
    logic [7:0]  r_ramp_count, n_ramp_count;

    logic          w_done, w_timed_out;
    t_cmd          w_cmd;
    logic [15:0]   w_tick_inc;
    logic [7:0]    w_ramp_inc;
    logic [PERIOD_W:0] w_sum;

    assign w_cmd      = t_cmd'(i_cmd);
    assign w_tick_inc = r_tick_count + 16'd1;
    assign w_ramp_inc = r_ramp_count + 8'd1;
    assign w_sum      = {1'b0, r_period} + (PERIOD_W+1)'(i_cfg.ramp_increment);

    always_comb begin
        n_moving       = r_moving;
        n_dir          = r_dir;
        n_step         = r_step;
        n_ramping      = r_ramping;
        n_period       = r_period;
        n_period_count = r_period_count;
        n_tick_count   = r_tick_count;
        n_elapsed      = r_elapsed;
        n_ramp_count   = r_ramp_count;
        w_done         = 1'b0;
        w_timed_out    = 1'b0;

        if (!r_moving) begin
            if ((w_cmd == CMD_OPEN && i_open_limit) || (w_cmd == CMD_CLOSE && i_close_limit)) begin
                w_done = 1'b1;
            end else if (w_cmd == CMD_OPEN || w_cmd == CMD_CLOSE) begin
                n_moving       = 1'b1;
                n_ramping      = 1'b1;
                n_dir          = (w_cmd == CMD_OPEN);
                n_period       = sat_start(i_cfg.start_period);
                n_period_count = '0;
                n_tick_count   = '0;
                n_elapsed      = '0;
                n_ramp_count   = '0;
            end
        end else if (r_dir ? i_open_limit : i_close_limit) begin
            n_moving  = 1'b0;
            n_ramping = 1'b0;
            w_done    = 1'b1;
        end else if (w_cmd == CMD_TICK) begin
            if (r_period_count >= r_period) begin
                n_step         = ~r_step;
                n_period_count = '0;
            end else begin
                n_period_count = r_period_count + t_period'(1);
            end

            if (w_tick_inc >= i_cfg.ticks_per_ms) begin
                n_tick_count = '0;
                n_elapsed    = (r_elapsed != 16'hFFFF) ? r_elapsed + 16'd1 : r_elapsed;
                n_ramp_count = w_ramp_inc;
                if (n_elapsed >= i_cfg.timeout_ms) begin
                    n_moving    = 1'b0;
                    n_ramping   = 1'b0;
                    w_done      = 1'b1;
                    w_timed_out = 1'b1;
                end else if (r_ramping && w_ramp_inc >= i_cfg.ramp_interval_ms) begin
                    n_ramp_count = '0;
                    if (32'(r_period) < 32'(i_cfg.end_period)) begin
                        n_period = w_sum[PERIOD_W] ? PERIOD_MAX : w_sum[PERIOD_W-1:0];
                    end else begin
                        n_ramping = 1'b0;
                    end
                end
            end else begin
                n_tick_count = w_tick_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moving       <= 1'b0;
            r_dir          <= 1'b0;
            r_step         <= 1'b0;
            r_ramping      <= 1'b0;
            r_period       <= sat_start(RST_START_PER);
            r_period_count <= '0;
            r_tick_count   <= '0;
            r_elapsed      <= '0;
            r_ramp_count   <= '0;
        end else if (i_fire) begin
            r_moving       <= n_moving;
            r_dir          <= n_dir;
            r_step         <= n_step;
            r_ramping      <= n_ramping;
            r_period       <= n_period;
            r_period_count <= n_period_count;
            r_tick_count   <= n_tick_count;
            r_elapsed      <= n_elapsed;
            r_ramp_count   <= n_ramp_count;
        end
    end

    always_comb begin
        o_res.step_level    = n_step;
        o_res.direction     = n_dir;
        o_res.driver_enable = n_moving;
        o_res.busy_res      = n_moving;
        o_res.done_res      = w_done;
        o_res.done_code     = w_timed_out;
        if (i_open_limit) begin
            o_res.position = POS_OPEN;
        end else if (i_close_limit) begin
            o_res.position = POS_CLOSE;
        end else begin
            o_res.position = POS_BETWEEN;
        end
    end

endmodule

// ===== tb/sv/tb_stepper_move_to_limit_top.sv =====
// Testbench for the stepper move-to-limit controller: random moves checked against a predictor.
`timescale 1ns / 100ps

module tb_stepper_move_to_limit_top;
    import smtl_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES  = 8;

    // Tracks the move state and holds the expected output of every accepted transaction.
    class move_scoreboard;
        logic [15:0] timeout_ms;
        logic [7:0]  ramp_interval_ms;
        logic [15:0] start_period;
        logic [15:0] end_period;
        logic [7:0]  ramp_increment;
        logic [15:0] ticks_per_ms;

        bit          moving;
        bit          toward_open;
        bit          step_pin;
        bit          ramping;
        t_period     period;
        t_period     period_count;
        logic [15:0] tick_count;
        logic [15:0] elapsed_ms;
        logic [7:0]  ramp_count;

        t_result     pending_results[$];
        int          errors;

        function new();
            timeout_ms       = RST_TIMEOUT;
            ramp_interval_ms = RST_RAMP_INT;
            start_period     = RST_START_PER;
            end_period       = RST_END_PER;
            ramp_increment   = RST_RAMP_INC;
            ticks_per_ms     = RST_TICKS_MS;
            moving           = 1'b0;
            toward_open      = 1'b0;
            step_pin         = 1'b0;
            ramping          = 1'b0;
            period           = sat_start(RST_START_PER);
            period_count     = '0;
            tick_count       = '0;
            elapsed_ms       = '0;
            ramp_count       = '0;
            errors           = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_TIMEOUT:   timeout_ms       = value[15:0];
                REG_RAMP_INT:  ramp_interval_ms = value[7:0];
                REG_START_PER: start_period     = value[15:0];
                REG_END_PER:   end_period       = value[15:0];
                REG_RAMP_INC:  ramp_increment   = value[7:0];
                REG_TICKS_MS:  ticks_per_ms     = value[15:0];
                default: ;
            endcase
        endfunction

        function void begin_move(bit open_side);
            moving       = 1'b1;
            ramping      = 1'b1;
            toward_open  = open_side;
            period       = sat_start(start_period);
            period_count = '0;
            tick_count   = '0;
            elapsed_ms   = '0;
            ramp_count   = '0;
        endfunction

        // Advance the move by one transaction and queue the output it must produce.
        function void apply_input(t_cmd cmd, bit open_lim, bit close_lim);
            t_result           r;
            bit                done;
            bit                timed_out;
            logic [PERIOD_W:0] grown;
            done      = 1'b0;
            timed_out = 1'b0;
            if (!moving) begin
                if (cmd == CMD_OPEN) begin
                    if (open_lim) done = 1'b1;
                    else begin_move(1'b1);
                end else if (cmd == CMD_CLOSE) begin
                    if (close_lim) done = 1'b1;
                    else begin_move(1'b0);
                end
            end else if (toward_open ? open_lim : close_lim) begin
                moving  = 1'b0;
                ramping = 1'b0;
                done    = 1'b1;
            end else if (cmd == CMD_TICK) begin
                if (period_count >= period) begin
                    step_pin     = ~step_pin;
                    period_count = '0;
                end else begin
                    period_count = period_count + t_period'(1);
                end
                tick_count = tick_count + 16'd1;
                if (tick_count >= ticks_per_ms) begin
                    tick_count = '0;
                    if (elapsed_ms != 16'hFFFF) elapsed_ms = elapsed_ms + 16'd1;
                    ramp_count = ramp_count + 8'd1;
                    // timeout takes priority over a ramp falling in the same ms
                    if (elapsed_ms >= timeout_ms) begin
                        moving    = 1'b0;
                        ramping   = 1'b0;
                        done      = 1'b1;
                        timed_out = 1'b1;
                    end else if (ramping && ramp_count >= ramp_interval_ms) begin
                        ramp_count = '0;
                        if (32'(period) < 32'(end_period)) begin
                            grown  = {1'b0, period} + (PERIOD_W+1)'(ramp_increment);
                            period = grown[PERIOD_W] ? PERIOD_MAX : grown[PERIOD_W-1:0];
                        end else begin
                            ramping = 1'b0;
                        end
                    end
                end
            end
            r.step_level    = step_pin;
            r.direction     = toward_open;
            r.driver_enable = moving;
            r.busy_res      = moving;
            r.done_res      = done;
            r.done_code     = timed_out;
            r.position      = open_lim ? POS_OPEN : (close_lim ? POS_CLOSE : POS_BETWEEN);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [1:0] want, logic [1:0] seen);
            if (want !== seen) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(t_result seen);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual %p", $time, seen);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("step_level", 2'(want.step_level), 2'(seen.step_level));
            compare_field("direction", 2'(want.direction), 2'(seen.direction));
            compare_field("driver_enable", 2'(want.driver_enable), 2'(seen.driver_enable));
            compare_field("busy_res", 2'(want.busy_res), 2'(seen.busy_res));
            compare_field("done_res", 2'(want.done_res), 2'(seen.done_res));
            compare_field("done_code", 2'(want.done_code), 2'(seen.done_code));
            compare_field("position", want.position, seen.position);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CFG_AW-1:0]   paddr = '0;
    logic [CFG_DW-1:0]   pwdata = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_cmd = CMD_TICK;
    logic                i_open_limit = 1'b0;
    logic                i_close_limit = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_step_level;
    logic                o_direction;
    logic                o_driver_enable;
    logic                o_busy_res;
    logic                o_done_res;
    logic                o_done_code;
    logic [1:0]          o_position;

    move_scoreboard sb = new();
    int             idle_pct = 20;
    int             stall_pct = 20;
    int             cycle_count = 0;

    stepper_move_to_limit_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_open_limit    (i_open_limit),
        .i_close_limit   (i_close_limit),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_step_level    (o_step_level),
        .o_direction     (o_direction),
        .o_driver_enable (o_driver_enable),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_done_code     (o_done_code),
        .o_position      (o_position)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = '{step_level: o_step_level, direction: o_direction,
                     driver_enable: o_driver_enable, busy_res: o_busy_res,
                     done_res: o_done_res, done_code: o_done_code,
                     position: o_position};
            sb.check_result(seen);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: run limit reached", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Present one transaction, with random idle cycles ahead of it, and hold until accepted.
    task automatic send(t_cmd cmd, bit open_lim, bit close_lim);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_open_limit  <= open_lim;
        i_close_limit <= close_lim;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.apply_input(cmd, open_lim, close_lim);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop any move in progress, let results drain, then program every register.
    task automatic load_settings(t_cfg c);
        if (sb.moving) send(CMD_TICK, 1'b1, 1'b1);
        drain();
        apb_write(REG_TIMEOUT, 32'(c.timeout_ms));
        apb_write(REG_RAMP_INT, 32'(c.ramp_interval_ms));
        apb_write(REG_START_PER, 32'(c.start_period));
        apb_write(REG_END_PER, 32'(c.end_period));
        apb_write(REG_RAMP_INC, 32'(c.ramp_increment));
        apb_write(REG_TICKS_MS, 32'(c.ticks_per_ms));
    endtask

    // Mostly well-formed moves: a request, a run of ticks, often the target limit at the end.
    task automatic run_moves(int budget);
        int sent;
        int len;
        int pick;
        bit open_side;
        bit target_hit;
        bit other_hit;
        sent = 0;
        while (sent < budget) begin
            open_side  = 1'($urandom_range(1));
            target_hit = ($urandom_range(9) == 0);
            other_hit  = ($urandom_range(3) == 0);
            if (open_side) send(CMD_OPEN, target_hit, other_hit);
            else send(CMD_CLOSE, other_hit, target_hit);
            len = $urandom_range(1, 30);
            repeat (len) begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    send(CMD_TICK, 1'b0, 1'b0);
                end else if (pick < 82) begin
                    // opposite switch active must not stop the move
                    send(CMD_TICK, !open_side, open_side);
                end else if (pick < 88) begin
                    send(t_cmd'($urandom_range(1, 2)), 1'b0, 1'b0);
                end else if (pick < 94) begin
                    send(CMD_NONE, 1'($urandom_range(1)), 1'($urandom_range(1)));
                end else begin
                    send(t_cmd'($urandom_range(3)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
                end
            end
            sent += len + 1;
            if ($urandom_range(1)) begin
                send(t_cmd'($urandom_range(3)), open_side, !open_side);
                sent++;
            end
        end
    endtask

    task automatic run_phase(t_cfg c, int budget, int idle);
        load_settings(c);
        idle_pct  = idle;
        stall_pct = idle;
        run_moves(budget);
    endtask

    initial begin
        t_cfg c;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: immediate completions, ignored requests, limit ends
        send(CMD_TICK, 1'b0, 1'b0);
        send(CMD_OPEN, 1'b1, 1'b0);
        send(CMD_CLOSE, 1'b0, 1'b1);
        send(CMD_NONE, 1'b1, 1'b1);
        send(CMD_OPEN, 1'b0, 1'b0);
        send(CMD_CLOSE, 1'b0, 1'b0);
        send(CMD_NONE, 1'b0, 1'b1);
        send(CMD_TICK, 1'b0, 1'b0);
        send(CMD_TICK, 1'b1, 1'b0);
        send(CMD_CLOSE, 1'b0, 1'b0);
        send(CMD_NONE, 1'b0, 1'b1);

        // all-zero registers: toggle every tick, timeout at the first ms
        c = '{timeout_ms: 16'd0, ramp_interval_ms: 8'd0, start_period: 16'd0,
              end_period: 16'd0, ramp_increment: 8'd0, ticks_per_ms: 16'd0};
        load_settings(c);
        send(CMD_OPEN, 1'b0, 1'b0);
        send(CMD_TICK, 1'b0, 1'b0);
        send(CMD_CLOSE, 1'b0, 1'b0);
        send(CMD_TICK, 1'b0, 1'b0);

        // ramp due in the same ms as the timeout
        c = '{timeout_ms: 16'd4, ramp_interval_ms: 8'd2, start_period: 16'd0,
              end_period: 16'd2, ramp_increment: 8'd1, ticks_per_ms: 16'd1};
        load_settings(c);
        send(CMD_CLOSE, 1'b0, 1'b0);
        repeat (5) send(CMD_TICK, 1'b0, 1'b0);

        // period saturates at its maximum
        c = '{timeout_ms: 16'd5, ramp_interval_ms: 8'd1, start_period: 16'd65400,
              end_period: 16'd65535, ramp_increment: 8'd255, ticks_per_ms: 16'd1};
        load_settings(c);
        send(CMD_OPEN, 1'b0, 1'b0);
        repeat (3) send(CMD_TICK, 1'b0, 1'b0);
        send(CMD_TICK, 1'b1, 1'b0);

        c = '{timeout_ms: 16'd20, ramp_interval_ms: 8'd3, start_period: 16'd2,
              end_period: 16'd12, ramp_increment: 8'd2, ticks_per_ms: 16'd2};
        run_phase(c, 80, 20);
        c = '{timeout_ms: 16'hFFFF, ramp_interval_ms: 8'hFF, start_period: 16'hFFFF,
              end_period: 16'hFFFF, ramp_increment: 8'hFF, ticks_per_ms: 16'd1};
        run_phase(c, 60, 20);
        c = '{timeout_ms: 16'd1, ramp_interval_ms: 8'd1, start_period: 16'd1,
              end_period: 16'd1, ramp_increment: 8'd0, ticks_per_ms: 16'd1};
        run_phase(c, 60, 20);
        // back-to-back stretch with no idling on either side
        c = '{timeout_ms: 16'd30, ramp_interval_ms: 8'd1, start_period: 16'd0,
              end_period: 16'hFFFF, ramp_increment: 8'hFF, ticks_per_ms: 16'd1};
        run_phase(c, 80, 0);
        // end period below start: ramping stops at the first ramp
        c = '{timeout_ms: 16'd12, ramp_interval_ms: 8'd2, start_period: 16'd3,
              end_period: 16'd1, ramp_increment: 8'd7, ticks_per_ms: 16'd3};
        run_phase(c, 60, 20);
        repeat (2) begin
            c.timeout_ms       = 16'($urandom_range(3, 40));
            c.ramp_interval_ms = 8'($urandom_range(1, 6));
            c.start_period     = 16'($urandom_range(0, 8));
            c.end_period       = 16'($urandom_range(0, 20));
            c.ramp_increment   = 8'($urandom_range(0, 5));
            c.ticks_per_ms     = 16'($urandom_range(1, 4));
            run_phase(c, 80, 20);
        end
        c = '{timeout_ms: RST_TIMEOUT, ramp_interval_ms: RST_RAMP_INT,
              start_period: RST_START_PER, end_period: RST_END_PER,
              ramp_increment: RST_RAMP_INC, ticks_per_ms: 16'hFFFF};
        run_phase(c, 40, 20);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/smtl_pkg.sv
rtl/core/smtl_regs.sv
rtl/core/smtl_core.sv
rtl/core/stepper_move_to_limit_top.sv
tb/sv/tb_stepper_move_to_limit_top.sv
